// ----- design/hexd_pkg.sv -----
package hexd_pkg;

   // widest prefix the block is built for; prefix_bytes carries at most four bytes
   localparam int MAX_PREFIX = 4;
   localparam int PREFIX_LIM = (MAX_PREFIX < 4) ? MAX_PREFIX : 4;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes of the csr port
   localparam logic CSR_PREFIX_LENGTH = 1'b0;
   localparam logic CSR_PREFIX_BYTES  = 1'b1;

   typedef enum logic [1:0] {
      PH_MATCH,
      PH_HIGH,
      PH_LOW_OK,
      PH_LOW_BAD
   } phase_type;

   typedef struct packed {
      logic [2:0]  prefix_length;
      logic [31:0] prefix_bytes;
   } csr_type;

   // one job: flush_cnt held prefix bytes, then an optional tail result
   typedef struct packed {
      logic [1:0] flush_cnt;
      logic       has_tail;
      logic [7:0] tail_byte;
      logic       tail_err;
      logic       last;
   } job_type;

   function automatic logic [2:0] eff_len(logic [2:0] pl);
      logic [2:0] n;
      n = pl;
      if (n == 3'd0) n = 3'd1;
      if (n > 3'(PREFIX_LIM)) n = 3'(PREFIX_LIM);
      return n;
   endfunction

   function automatic logic [7:0] prefix_at(logic [31:0] bytes, logic [1:0] k);
      return bytes[{k, 3'b000} +: 8];
   endfunction

   // 0..15 for a hex digit, 16 otherwise
   function automatic logic [4:0] hex_val(logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         v = {1'b0, c[3:0] + 4'd9};
      else v = 5'd16;
      return v;
   endfunction

endpackage

// ----- design/hexd_front.sv -----
module hexd_front
   import hexd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  csr_type    csr,
   input  logic       q_full,
   output logic       push,
   output job_type    push_job
);

   phase_type  phase_ff, phase_in;
   logic [1:0] match_count_ff, match_count_in;
   logic [3:0] high_ff, high_in;

   logic       accept;
   logic [2:0] len;
   logic [1:0] mc_cl;
   logic [2:0] mc_inc;
   logic       hit;
   logic       full_match;
   logic [4:0] hv;
   logic       hv_ok;

   assign req_stall  = q_full;
   assign accept     = req_valid & ~q_full;
   assign len        = eff_len(csr.prefix_length);
   // stale count after a length change
   assign mc_cl      = ({1'b0, match_count_ff} >= len) ? 2'(len - 3'd1) : match_count_ff;
   assign mc_inc     = {1'b0, mc_cl} + 3'd1;
   assign hit        = (req_in_byte == prefix_at(csr.prefix_bytes, mc_cl));
   assign full_match = (mc_inc == len);
   assign hv         = hex_val(req_in_byte);
   assign hv_ok      = ~hv[4];

   // next state
   always_comb begin
      phase_in       = phase_ff;
      match_count_in = match_count_ff;
      high_in        = high_ff;
      if (accept) begin
         case (phase_ff)
            PH_MATCH: begin
               if (hit && full_match) begin
                  match_count_in = 2'd0;
                  phase_in       = req_in_last ? PH_MATCH : PH_HIGH;
               end else if (hit && !req_in_last) begin
                  match_count_in = mc_inc[1:0];
               end else begin
                  match_count_in = 2'd0;
               end
            end
            PH_HIGH: begin
               if (req_in_last) begin
                  phase_in = PH_MATCH;
                  high_in  = 4'd0;
               end else begin
                  phase_in = hv_ok ? PH_LOW_OK : PH_LOW_BAD;
                  high_in  = hv[3:0];
               end
            end
            default: begin
               phase_in = PH_MATCH;
               high_in  = 4'd0;
            end
         endcase
      end
   end

   // job to the queue
   always_comb begin
      push          = 1'b0;
      push_job      = '0;
      push_job.last = req_in_last;
      if (accept) begin
         case (phase_ff)
            PH_MATCH: begin
               if (hit && full_match) begin
                  if (req_in_last) begin
                     push              = 1'b1;
                     push_job.has_tail = 1'b1;
                     push_job.tail_err = 1'b1;
                  end
               end else if (hit) begin
                  if (req_in_last) begin
                     push               = 1'b1;
                     push_job.flush_cnt = mc_inc[1:0];
                  end
               end else begin
                  push               = 1'b1;
                  push_job.flush_cnt = mc_cl;
                  push_job.has_tail  = 1'b1;
                  push_job.tail_byte = req_in_byte;
               end
            end
            PH_HIGH: begin
               if (req_in_last) begin
                  push              = 1'b1;
                  push_job.has_tail = 1'b1;
                  push_job.tail_err = 1'b1;
               end
            end
            PH_LOW_OK: begin
               push               = 1'b1;
               push_job.has_tail  = 1'b1;
               push_job.tail_byte = hv_ok ? {high_ff, hv[3:0]} : 8'd0;
               push_job.tail_err  = ~hv_ok;
            end
            default: begin
               push              = 1'b1;
               push_job.has_tail = 1'b1;
               push_job.tail_err = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MATCH;
         match_count_ff <= 2'd0;
         high_ff        <= 4'd0;
      end else begin
         phase_ff       <= phase_in;
         match_count_ff <= match_count_in;
         high_ff        <= high_in;
      end
   end

   a_count_only_matching: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_MATCH |-> match_count_ff == 2'd0)
      else $error("prefix count held outside prefix matching");

   a_nibble_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_MATCH |-> high_ff == 4'd0)
      else $error("high nibble not cleared");

endmodule

// ----- design/hexd_queue.sv -----
module hexd_queue
   import hexd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      if (pop)  rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wptr_ff] <= push_job;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("job queue underflow");

endmodule

// ----- design/hexd_back.sv -----
module hexd_back
   import hexd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] prefix_bytes,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_error,
   output logic        rsp_run_last,
   output logic        rsp_message_end
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       err_ff, err_in;
   logic       run_last_ff, run_last_in;
   logic       msg_end_ff, msg_end_in;

   logic       out_free;
   logic       emit;
   logic       in_tail;
   logic       final_res;

   assign out_free  = ~valid_ff | ~rsp_stall;
   assign emit      = head_valid & out_free;
   assign in_tail   = (idx_ff == head_job.flush_cnt);
   assign final_res = head_job.has_tail ? in_tail : (idx_ff == head_job.flush_cnt - 2'd1);
   assign pop       = emit & final_res;

   always_comb begin
      idx_in      = idx_ff;
      valid_in    = valid_ff & rsp_stall;
      byte_in     = byte_ff;
      err_in      = err_ff;
      run_last_in = run_last_ff;
      msg_end_in  = msg_end_ff;
      if (emit) begin
         idx_in      = final_res ? 2'd0 : idx_ff + 2'd1;
         valid_in    = 1'b1;
         byte_in     = in_tail ? head_job.tail_byte : prefix_at(prefix_bytes, idx_ff);
         err_in      = in_tail & head_job.tail_err;
         run_last_in = final_res;
         msg_end_in  = final_res & head_job.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      err_ff      <= err_in;
      run_last_ff <= run_last_in;
      msg_end_ff  <= msg_end_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_out_error   = err_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_message_end = msg_end_ff;

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && msg_end_ff |-> run_last_ff)
      else $error("message end without run last");

   a_error_byte_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && err_ff |-> byte_ff == 8'd0)
      else $error("error result carries data");

endmodule

// ----- design/hex_escape_decoder.sv -----
// hex_escape_decoder: undoes prefixed hex escapes in a byte stream
//
// req channel: one message byte per transaction (req_in_byte, req_in_last marks the
// final byte). rsp channel: zero to four result transactions per input byte, each
// with rsp_out_byte, rsp_out_error, rsp_run_last (last result of that input byte)
// and rsp_message_end (last result of the message). csr port: index 0 is the
// prefix length, index 1 the packed prefix bytes; write only while idle.
// a result passes the job queue and then the result register on its way to rsp.
// throughput: one byte per cycle while rsp_stall is low and bytes give at most one
// result each; results of a byte that releases held prefix bytes pass the result
// register one at a time; the front keeps taking bytes until the two-entry queue fills.
// reset clears the matching state, empties the queue and the result register and
// loads prefix length 1 with prefix '%'.
// when rsp_stall is high the result register holds its transaction; the back end
// stops, the queue fills and then req_stall goes high.
module hex_escape_decoder
   import hexd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_error,
   output logic        rsp_run_last,
   output logic        rsp_message_end,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   csr_type csr_ff, csr_in;

   // jobs between front and back
   logic    push;
   job_type push_job;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   // configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PREFIX_LENGTH: csr_in.prefix_length = csr_wdata[2:0];
            CSR_PREFIX_BYTES:  csr_in.prefix_bytes  = csr_wdata;
            default:           csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.prefix_length <= 3'd1;
         csr_ff.prefix_bytes  <= 32'd37;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // front: prefix matching and hex digit tracking, one byte per cycle while the job queue is not full
   hexd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .csr         (csr_ff),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   // short job queue decoupling the two sides
   hexd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // back: expands each job into result transactions
   hexd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .prefix_bytes    (csr_ff.prefix_bytes),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_error   (rsp_out_error),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end)
   );

endmodule
